@@ src/jst_pkg.sv @@
// Package for the JSON stream tokenizer.
// Holds parse mode, event and error codes, character constants and literal tables.
// No dependencies.
package jst_pkg;

  localparam int DEF_MAX_DEPTH     = 64;
  localparam int DEF_POSITION_BITS = 24;

  // parse modes
  localparam logic [3:0] M_ROOT      = 4'd0;
  localparam logic [3:0] M_ARR_VALUE = 4'd1;
  localparam logic [3:0] M_ARR_AFTER = 4'd2;
  localparam logic [3:0] M_OBJ_KEY   = 4'd3;
  localparam logic [3:0] M_OBJ_COLON = 4'd4;
  localparam logic [3:0] M_OBJ_VALUE = 4'd5;
  localparam logic [3:0] M_OBJ_AFTER = 4'd6;
  localparam logic [3:0] M_KEY       = 4'd7;
  localparam logic [3:0] M_STR       = 4'd8;
  localparam logic [3:0] M_NUM       = 4'd9;
  localparam logic [3:0] M_LIT_T     = 4'd10;
  localparam logic [3:0] M_LIT_F     = 4'd11;
  localparam logic [3:0] M_LIT_N     = 4'd12;
  localparam logic [3:0] M_DONE      = 4'd13;
  localparam logic [3:0] M_ERROR     = 4'd14;

  // event codes
  localparam logic [3:0] EV_OPEN_OBJ  = 4'd0;
  localparam logic [3:0] EV_OPEN_ARR  = 4'd1;
  localparam logic [3:0] EV_CLOSE_OBJ = 4'd2;
  localparam logic [3:0] EV_CLOSE_ARR = 4'd3;
  localparam logic [3:0] EV_KEY_BYTE  = 4'd4;
  localparam logic [3:0] EV_KEY_END   = 4'd5;
  localparam logic [3:0] EV_STR_BYTE  = 4'd6;
  localparam logic [3:0] EV_STR_END   = 4'd7;
  localparam logic [3:0] EV_NUM_BYTE  = 4'd8;
  localparam logic [3:0] EV_NUM_END   = 4'd9;
  localparam logic [3:0] EV_TRUE      = 4'd10;
  localparam logic [3:0] EV_ERROR     = 4'd13;
  localparam logic [3:0] EV_DONE      = 4'd14;

  // error codes
  localparam logic [3:0] ER_EXP_STRING = 4'd0;
  localparam logic [3:0] ER_UNTERM_STR = 4'd1;
  localparam logic [3:0] ER_UNTERM_ARR = 4'd2;
  localparam logic [3:0] ER_UNTERM_OBJ = 4'd3;
  localparam logic [3:0] ER_EXP_COLON  = 4'd4;
  localparam logic [3:0] ER_UNEXP_END  = 4'd5;
  localparam logic [3:0] ER_BAD_TRUE   = 4'd6;
  localparam logic [3:0] ER_INVALID    = 4'd9;
  localparam logic [3:0] ER_TOO_DEEP   = 4'd10;

  // characters
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_POINT  = 8'h2E;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;

  // literal length: true, false, null
  function automatic logic [2:0] lit_len(input logic [1:0] k);
    case (k)
      2'd1:    lit_len = 3'd5;
      default: lit_len = 3'd4;
    endcase
  endfunction

  // literal character at a position
  function automatic logic [7:0] lit_char(input logic [1:0] k, input logic [2:0] idx);
    logic [39:0] txt;
    case (k)
      2'd0:    txt = {"true", 8'h00};
      2'd1:    txt = "false";
      default: txt = {"null", 8'h00};
    endcase
    case (idx)
      3'd0:    lit_char = txt[39:32];
      3'd1:    lit_char = txt[31:24];
      3'd2:    lit_char = txt[23:16];
      3'd3:    lit_char = txt[15:8];
      3'd4:    lit_char = txt[7:0];
      default: lit_char = 8'h00;
    endcase
  endfunction

endpackage

@@ src/jst_stack.sv @@
// Container nesting stack for the JSON tokenizer: one-bit entries in a
// synchronous memory, top cached in a register, entry below prefetched.
// Depends on jst_pkg.
module jst_stack #(
  parameter int MAX_DEPTH = jst_pkg::DEF_MAX_DEPTH,
  parameter int DW        = $clog2(MAX_DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic          push_bit,
  input  logic          pop,
  input  logic          clear,
  output logic [DW-1:0] depth,
  output logic          tos,
  output logic          below
);
  import jst_pkg::*;

  localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  logic          mem [MAX_DEPTH];
  logic [DW-1:0] depth_r, depth_nxt;
  logic          tos_r, tos_nxt;
  logic          below_r;
  logic [DW-1:0] rd_full;
  logic [AW-1:0] wr_addr, rd_addr;

  // next depth and top
  always_comb begin
    depth_nxt = depth_r;
    tos_nxt   = tos_r;
    if (clear) begin
      depth_nxt = '0;
    end else if (push) begin
      depth_nxt = depth_r + DW'(1);
      tos_nxt   = push_bit;
    end else if (pop) begin
      depth_nxt = depth_r - DW'(1);
      tos_nxt   = below_r;
    end
  end

  assign rd_full = depth_nxt - DW'(2);
  assign rd_addr = rd_full[AW-1:0];
  assign wr_addr = depth_r[AW-1:0];

  // push writes the new top; read prefetches the entry under the next top
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_addr] <= push_bit;
    end
    below_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
      tos_r   <= 1'b0;
    end else begin
      depth_r <= depth_nxt;
      tos_r   <= tos_nxt;
    end
  end

  assign depth = depth_r;
  assign tos   = tos_r;
  assign below = below_r;

endmodule

@@ src/jst_outq.sv @@
// Result queue for the JSON tokenizer: takes up to two items a cycle,
// hands one item a cycle to the output channel while it does not stall.
// Depends on jst_pkg.
module jst_outq #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic [1:0]   wr_cnt,
  input  logic [W-1:0] wr_data0,
  input  logic [W-1:0] wr_data1,
  output logic         full,
  output logic         rd_valid,
  input  logic         rd_stall,
  output logic [W-1:0] rd_data
);
  import jst_pkg::*;

  logic [W-1:0] slot_r [4];
  logic [1:0]   head_r, tail_r;
  logic [2:0]   count_r;
  logic         rd_take;
  logic [1:0]   tail_p1;

  assign rd_valid = (count_r != 3'd0);
  assign rd_take  = rd_valid && !rd_stall;
  assign rd_data  = slot_r[head_r];
  assign full     = (count_r > 3'd2);
  assign tail_p1  = tail_r + 2'd1;

  // store incoming items
  always_ff @(posedge clk) begin
    if (wr_cnt != 2'd0) begin
      slot_r[tail_r] <= wr_data0;
    end
    if (wr_cnt == 2'd2) begin
      slot_r[tail_p1] <= wr_data1;
    end
  end

  // advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      tail_r  <= tail_r + wr_cnt;
      head_r  <= head_r + {1'b0, rd_take};
      count_r <= count_r + {1'b0, wr_cnt} - {2'b00, rd_take};
    end
  end

endmodule

@@ src/json_stream_tokenizer.sv @@
// JSON stream tokenizer top level: parse mode logic, counters, stack and result queue.
// Depends on jst_pkg, jst_stack and jst_outq.
//
//  channel | direction | ports
//  in      | input     | in_valid, in_stall, in_data_byte, in_end_of_input
//  out     | output    | out_valid, out_stall, out_event_res .. out_last_of_run
//
// One byte item is taken per cycle while the input does not stall; it yields
// zero, one or two result items. The stack memory is read in the cycle before
// the entry is needed, so a pop every cycle keeps full rate. A four-entry result
// queue holds results; input stalls while more than two wait. Reset is
// synchronous; the end item resets the parse state in the cycle it is taken.
module json_stream_tokenizer #(
  parameter int MAX_DEPTH     = jst_pkg::DEF_MAX_DEPTH,
  parameter int POSITION_BITS = jst_pkg::DEF_POSITION_BITS,
  parameter int NW            = $clog2(MAX_DEPTH + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [7:0]               in_data_byte,
  input  logic                     in_end_of_input,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [3:0]               out_event_res,
  output logic [7:0]               out_payload,
  output logic [3:0]               out_error_code,
  output logic [POSITION_BITS-1:0] out_line_number,
  output logic [POSITION_BITS-1:0] out_column_number,
  output logic [NW-1:0]            out_nesting_level,
  output logic                     out_last_of_run
);
  import jst_pkg::*;

  localparam int P  = POSITION_BITS;
  localparam int RW = 4 + 8 + 4 + P + P + NW + 1;
  localparam logic [NW-1:0] DEPTH_MAX = NW'(MAX_DEPTH);

  logic [3:0]    mode_r, mode_nxt;
  logic [2:0]    idx_r, idx_nxt;
  logic          esc_r, esc_nxt;
  logic          dec_r, dec_nxt;
  logic [P-1:0]  line_r, line_nxt;
  logic [P-1:0]  col_r, col_nxt;
  logic [P-1:0]  litcol_r, litcol_nxt;

  logic          accept, q_full;
  logic [NW-1:0] depth;
  logic          tos, below;
  logic          push, push_bit, pop, clear;

  logic          numend, handled, emit;
  logic [3:0]    eff, ev, err;
  logic [7:0]    pl;
  logic [P-1:0]  ecol;
  logic [NW-1:0] enest;
  logic [1:0]    k;
  logic [1:0]    wr_cnt;
  logic [RW-1:0] r0, r1, rq;
  logic          isws, isdig;

  function automatic logic [P-1:0] sat_inc(input logic [P-1:0] v);
    sat_inc = (v == {P{1'b1}}) ? v : v + P'(1);
  endfunction

  function automatic logic [3:0] after_val(input logic [NW-1:0] d, input logic obj);
    if (d == '0)     after_val = M_DONE;
    else if (obj)    after_val = M_OBJ_AFTER;
    else             after_val = M_ARR_AFTER;
  endfunction

  assign accept = in_valid && !in_stall;
  assign in_stall = q_full;
  assign isws  = (in_data_byte == CH_SPACE) || (in_data_byte == CH_TAB) ||
                 (in_data_byte == CH_CR) || (in_data_byte == CH_LF);
  assign isdig = (in_data_byte >= CH_ZERO) && (in_data_byte <= CH_NINE);
  assign k     = 2'(eff - M_LIT_T);

  // parse one item
  always_comb begin
    mode_nxt   = mode_r;
    idx_nxt    = idx_r;
    esc_nxt    = esc_r;
    dec_nxt    = dec_r;
    line_nxt   = line_r;
    col_nxt    = col_r;
    litcol_nxt = litcol_r;
    push       = 1'b0;
    push_bit   = 1'b0;
    pop        = 1'b0;
    clear      = 1'b0;
    numend     = 1'b0;
    handled    = 1'b0;
    emit       = 1'b0;
    ev         = EV_ERROR;
    pl         = 8'h00;
    err        = 4'd0;
    ecol       = col_r;
    enest      = depth;
    eff        = mode_r;

    // finish or extend a pending number
    if (mode_r == M_NUM) begin
      if (!in_end_of_input && (isdig || (in_data_byte == CH_POINT && !dec_r))) begin
        handled = 1'b1;
        emit    = 1'b1;
        ev      = EV_NUM_BYTE;
        pl      = in_data_byte;
        col_nxt = sat_inc(col_r);
        if (in_data_byte == CH_POINT) dec_nxt = 1'b1;
      end else begin
        numend = 1'b1;
        eff    = after_val(depth, tos);
      end
    end
    mode_nxt = eff;

    if (in_end_of_input) begin
      // judge the end, then reset
      emit = 1'b1;
      case (eff)
        M_ROOT, M_OBJ_VALUE:    err = ER_UNEXP_END;
        M_ARR_VALUE, M_ARR_AFTER: err = ER_UNTERM_ARR;
        M_OBJ_KEY, M_OBJ_AFTER: err = ER_UNTERM_OBJ;
        M_OBJ_COLON:            err = ER_EXP_COLON;
        M_KEY, M_STR:           err = ER_UNTERM_STR;
        M_LIT_T, M_LIT_F, M_LIT_N: begin
          err  = ER_BAD_TRUE + {2'b00, k};
          ecol = litcol_r;
        end
        M_DONE:  ev = EV_DONE;
        default: emit = 1'b0;
      endcase
      clear      = 1'b1;
      mode_nxt   = M_ROOT;
      idx_nxt    = '0;
      esc_nxt    = 1'b0;
      dec_nxt    = 1'b0;
      line_nxt   = P'(1);
      col_nxt    = '0;
      litcol_nxt = '0;
    end else if (!handled) begin
      case (eff)
        M_ROOT, M_OBJ_VALUE, M_ARR_VALUE, M_ARR_AFTER,
        M_OBJ_KEY, M_OBJ_AFTER, M_OBJ_COLON: begin
          if (isws) begin
            // skip whitespace; LF starts a new line
            if (in_data_byte == CH_LF) begin
              line_nxt = sat_inc(line_r);
              col_nxt  = '0;
            end else begin
              col_nxt = sat_inc(col_r);
            end
          end else if ((in_data_byte == CH_RBRACK &&
                        (eff == M_ARR_VALUE || eff == M_ARR_AFTER)) ||
                       (in_data_byte == CH_RBRACE &&
                        (eff == M_OBJ_KEY || eff == M_OBJ_AFTER))) begin
            // close container
            emit     = 1'b1;
            ev       = (in_data_byte == CH_RBRACE) ? EV_CLOSE_OBJ : EV_CLOSE_ARR;
            pop      = (depth != '0);
            enest    = (depth != '0) ? depth - NW'(1) : depth;
            col_nxt  = sat_inc(col_r);
            mode_nxt = after_val(enest, below);
          end else if (in_data_byte == CH_COMMA && eff == M_ARR_AFTER) begin
            col_nxt  = sat_inc(col_r);
            mode_nxt = M_ARR_VALUE;
          end else if (in_data_byte == CH_COMMA && eff == M_OBJ_AFTER) begin
            col_nxt  = sat_inc(col_r);
            mode_nxt = M_OBJ_KEY;
          end else if (eff == M_OBJ_COLON) begin
            if (in_data_byte == CH_COLON) begin
              col_nxt  = sat_inc(col_r);
              mode_nxt = M_OBJ_VALUE;
            end else begin
              emit     = 1'b1;
              err      = ER_EXP_COLON;
              mode_nxt = M_ERROR;
            end
          end else if (eff == M_OBJ_KEY || eff == M_OBJ_AFTER) begin
            if (in_data_byte == CH_QUOTE) begin
              col_nxt  = sat_inc(col_r);
              esc_nxt  = 1'b0;
              mode_nxt = M_KEY;
            end else begin
              emit     = 1'b1;
              err      = ER_EXP_STRING;
              mode_nxt = M_ERROR;
            end
          end else if (in_data_byte == CH_QUOTE) begin
            // start a value
            esc_nxt  = 1'b0;
            mode_nxt = M_STR;
            col_nxt  = sat_inc(col_r);
          end else if (in_data_byte == CH_LBRACE || in_data_byte == CH_LBRACK) begin
            emit = 1'b1;
            if (depth >= DEPTH_MAX) begin
              err      = ER_TOO_DEEP;
              mode_nxt = M_ERROR;
            end else begin
              push     = 1'b1;
              push_bit = (in_data_byte == CH_LBRACE);
              enest    = depth + NW'(1);
              ev       = push_bit ? EV_OPEN_OBJ : EV_OPEN_ARR;
              mode_nxt = push_bit ? M_OBJ_KEY : M_ARR_VALUE;
              col_nxt  = sat_inc(col_r);
            end
          end else if (in_data_byte == CH_T || in_data_byte == CH_F ||
                       in_data_byte == CH_N) begin
            litcol_nxt = col_r;
            idx_nxt    = 3'd1;
            mode_nxt   = (in_data_byte == CH_T) ? M_LIT_T :
                         (in_data_byte == CH_F) ? M_LIT_F : M_LIT_N;
            col_nxt    = sat_inc(col_r);
          end else if (in_data_byte == CH_MINUS || isdig) begin
            emit     = 1'b1;
            ev       = EV_NUM_BYTE;
            pl       = in_data_byte;
            dec_nxt  = 1'b0;
            mode_nxt = M_NUM;
            col_nxt  = sat_inc(col_r);
          end else begin
            emit     = 1'b1;
            err      = ER_INVALID;
            mode_nxt = M_ERROR;
          end
        end
        M_KEY, M_STR: begin
          emit    = 1'b1;
          col_nxt = sat_inc(col_r);
          if (!esc_r && in_data_byte == CH_QUOTE) begin
            ev       = (eff == M_KEY) ? EV_KEY_END : EV_STR_END;
            mode_nxt = (eff == M_KEY) ? M_OBJ_COLON : after_val(depth, tos);
          end else begin
            ev      = (eff == M_KEY) ? EV_KEY_BYTE : EV_STR_BYTE;
            pl      = in_data_byte;
            esc_nxt = esc_r ? 1'b0 : (in_data_byte == CH_BSLASH);
          end
        end
        M_LIT_T, M_LIT_F, M_LIT_N: begin
          if (idx_r < lit_len(k) && in_data_byte == lit_char(k, idx_r)) begin
            col_nxt = sat_inc(col_r);
            idx_nxt = idx_r + 3'd1;
            if (idx_r + 3'd1 >= lit_len(k)) begin
              // the literal event carries the column after its last byte
              emit     = 1'b1;
              ev       = EV_TRUE + {2'b00, k};
              ecol     = col_nxt;
              idx_nxt  = '0;
              mode_nxt = after_val(depth, tos);
            end
          end else begin
            emit     = 1'b1;
            err      = ER_BAD_TRUE + {2'b00, k};
            ecol     = litcol_r;
            mode_nxt = M_ERROR;
          end
        end
        default: begin
          // done or error: drop the byte
        end
      endcase
    end
  end

  // pack results; number end goes first
  always_comb begin
    logic [RW-1:0] rn, rm;
    rn = {EV_NUM_END, 8'h00, 4'd0, line_r, col_r, depth, 1'b0};
    rm = {ev, pl, (ev == EV_ERROR) ? err : 4'd0, line_r, ecol, enest, 1'b0};
    wr_cnt = 2'd0;
    r0     = rm;
    r1     = rm;
    if (accept) begin
      if (numend && emit) begin
        wr_cnt = 2'd2;
        r0     = rn;
        r1     = rm | RW'(1);
      end else if (numend) begin
        wr_cnt = 2'd1;
        r0     = rn | RW'(1);
      end else if (emit) begin
        wr_cnt = 2'd1;
        r0     = rm | RW'(1);
      end
    end
  end

  // hold parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_ROOT;
      idx_r    <= '0;
      esc_r    <= 1'b0;
      dec_r    <= 1'b0;
      line_r   <= P'(1);
      col_r    <= '0;
      litcol_r <= '0;
    end else if (accept) begin
      mode_r   <= mode_nxt;
      idx_r    <= idx_nxt;
      esc_r    <= esc_nxt;
      dec_r    <= dec_nxt;
      line_r   <= line_nxt;
      col_r    <= col_nxt;
      litcol_r <= litcol_nxt;
    end
  end

  jst_stack #(
    .MAX_DEPTH (MAX_DEPTH),
    .DW        (NW)
  ) u_stack (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (accept && push),
    .push_bit (push_bit),
    .pop      (accept && pop),
    .clear    (accept && clear),
    .depth    (depth),
    .tos      (tos),
    .below    (below)
  );

  jst_outq #(
    .W (RW)
  ) u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_cnt   (wr_cnt),
    .wr_data0 (r0),
    .wr_data1 (r1),
    .full     (q_full),
    .rd_valid (out_valid),
    .rd_stall (out_stall),
    .rd_data  (rq)
  );

  assign {out_event_res, out_payload, out_error_code, out_line_number,
          out_column_number, out_nesting_level, out_last_of_run} = rq;

endmodule
